/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SFFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define SFFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sffd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sffd_pkg;

    localparam int C_SAMPLE_BITS   = 16;
    localparam int C_ADDR_BITS     = 16;
    localparam int C_BUFFER_DEPTH  = 1 << C_ADDR_BITS;
    localparam int C_ROW_BITS      = 2 * C_SAMPLE_BITS;
    localparam int C_LEN_BITS      = 24;
    localparam int C_RATE_BITS     = 16;
    localparam int C_FRAC_BITS     = 8;
    localparam int C_CFG_IDX_BITS  = 3;
    localparam int C_CFG_DATA_BITS = 24;
    localparam int C_PROD_BITS     = 2 * C_SAMPLE_BITS;
    localparam int C_INTERP_BITS   = C_SAMPLE_BITS + 11;

    localparam longint C_SPAN_MAX = longint'(C_BUFFER_DEPTH) * 256 - 1;
    localparam logic [C_LEN_BITS-1:0] C_LEN_LIMIT =
        (C_SPAN_MAX > 64'hFF_FFFF) ? 24'hFF_FFFF : C_LEN_BITS'(C_SPAN_MAX);

    localparam logic [C_LEN_BITS-1:0]  C_RST_DELAY_TARGET = '0;
    localparam logic [C_LEN_BITS-1:0]  C_RST_START_LENGTH = '0;
    localparam logic [C_RATE_BITS-1:0] C_RST_SMOOTH_RATE  = 16'd256;
    localparam logic signed [C_SAMPLE_BITS-1:0] C_RST_FEEDBACK_GAIN = 16'sd29491;

    localparam logic signed [C_SAMPLE_BITS-1:0] C_SMAX = {1'b0, {(C_SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [C_SAMPLE_BITS-1:0] C_SMIN = {1'b1, {(C_SAMPLE_BITS-1){1'b0}}};

    typedef logic signed [C_SAMPLE_BITS-1:0] t_sample;
    typedef logic [C_ADDR_BITS-1:0]          t_addr;
    typedef logic [C_ROW_BITS-1:0]           t_row;
    typedef logic [C_LEN_BITS-1:0]           t_len;
    typedef logic signed [C_PROD_BITS-1:0]   t_prod;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SCALE = 2'd1,
        CMD_ADD   = 2'd2
    } t_cmd;

    typedef enum logic [C_CFG_IDX_BITS-1:0] {
        CFG_DELAY_TARGET  = 3'd0,
        CFG_START_LENGTH  = 3'd1,
        CFG_SMOOTH_RATE   = 3'd2,
        CFG_FEEDBACK_GAIN = 3'd3,
        CFG_INPUT_OPEN    = 3'd4,
        CFG_OUTPUT_OPEN   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RAMP,
        S_RD_POS,
        S_RD_NEXT,
        S_INTERP,
        S_FBMUL,
        S_WRITE,
        S_SCALE_RD,
        S_SCALE_MUL,
        S_SCALE_WR,
        S_ADD_RD,
        S_ADD_WR
    } t_state;

    typedef enum logic [1:0] {
        RD_WI,
        RD_POS,
        RD_NEXT,
        RD_SLOT
    } t_rd_src;

    typedef struct packed {
        logic    load_item;
        logic    clear_step;
        logic    ramp;
        t_rd_src rd_src;
        logic    latch_w1;
        logic    latch_s0;
        logic    latch_dly;
        logic    latch_fb;
        logic    tick_write;
        logic    latch_prod;
        logic    scale_write;
        logic    add_write;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic out_full;
    } t_dp_stat;

    function automatic t_sample sat_add(input t_sample a, input t_sample b);
        logic signed [C_SAMPLE_BITS:0] s;
        s = (C_SAMPLE_BITS+1)'(a) + (C_SAMPLE_BITS+1)'(b);
        if (s[C_SAMPLE_BITS] != s[C_SAMPLE_BITS-1]) begin
            return s[C_SAMPLE_BITS] ? C_SMIN : C_SMAX;
        end
        return s[C_SAMPLE_BITS-1:0];
    endfunction

    // round half up, floor shift, saturate
    function automatic t_sample q_round(input t_prod p);
        logic signed [C_PROD_BITS:0]          t;
        logic signed [C_PROD_BITS-C_SAMPLE_BITS+1:0] sh;
        t  = (C_PROD_BITS+1)'(p) + ((C_PROD_BITS+1)'(1) <<< (C_SAMPLE_BITS-2));
        sh = $signed(t[C_PROD_BITS:C_SAMPLE_BITS-1]);
        if (sh > (C_PROD_BITS-C_SAMPLE_BITS+2)'(C_SMAX)) begin
            return C_SMAX;
        end
        if (sh < (C_PROD_BITS-C_SAMPLE_BITS+2)'(C_SMIN)) begin
            return C_SMIN;
        end
        return sh[C_SAMPLE_BITS-1:0];
    endfunction

    function automatic t_sample interp(input t_sample s0, input t_sample s1,
                                       input logic [C_FRAC_BITS-1:0] fr);
        logic signed [C_FRAC_BITS+1:0]   wa;
        logic signed [C_FRAC_BITS+1:0]   wb;
        logic signed [C_INTERP_BITS-1:0] acc;
        wa  = $signed({1'b0, 9'(10'd256 - {2'b0, fr})});
        wb  = $signed({2'b0, fr});
        acc = C_INTERP_BITS'(s0) * C_INTERP_BITS'(wa)
            + C_INTERP_BITS'(s1) * C_INTERP_BITS'(wb)
            + C_INTERP_BITS'(128);
        return acc[C_SAMPLE_BITS+C_FRAC_BITS-1:C_FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sffd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sffd_in_if;
    import sffd_pkg::*;

    logic         valid;
    logic         ready;
    logic [1:0]   command;
    t_sample      in_left;
    t_sample      in_right;
    t_sample      scale_coef;
    logic [15:0]  slot_offset;
    logic         slot_channel;

    modport source (
        output valid, command, in_left, in_right, scale_coef, slot_offset, slot_channel,
        input  ready
    );

    modport sink (
        input  valid, command, in_left, in_right, scale_coef, slot_offset, slot_channel,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/sffd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sffd_out_if;
    import sffd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample out_left;
    t_sample out_right;

    modport source (
        output valid, out_left, out_right,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_right,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/sffd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sffd_ram #(
    parameter int WIDTH = sffd_pkg::C_ROW_BITS,
    parameter int DEPTH = sffd_pkg::C_BUFFER_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

/* hw/rtl/sffd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sffd_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire sffd_pkg::t_dp_cmd                    i_cmd,
    output sffd_pkg::t_dp_stat                        o_stat,
    input  wire sffd_pkg::t_sample                    i_in_left,
    input  wire sffd_pkg::t_sample                    i_in_right,
    input  wire sffd_pkg::t_sample                    i_scale_coef,
    input  wire logic [15:0]                          i_slot_offset,
    input  wire logic                                 i_slot_channel,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output sffd_pkg::t_sample                         o_out_left,
    output sffd_pkg::t_sample                         o_out_right,
    input  wire logic                                 i_cfg_we,
    input  wire logic [sffd_pkg::C_CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [sffd_pkg::C_CFG_DATA_BITS-1:0] i_cfg_data
);
    import sffd_pkg::*;

    t_len                   r_delay_target;
    logic [C_RATE_BITS-1:0] r_smooth_rate;
    t_sample                r_fb_gain;
    logic                   r_input_open;
    logic                   r_output_open;

    t_addr   r_wi;
    t_len    r_cur;
    t_len    n_cur;
    t_addr   r_clr_addr;
    logic    r_out_valid;

    t_sample r_in_left;
    t_sample r_in_right;
    t_sample r_coef;
    t_addr   r_off;
    logic    r_ch;

    t_row    r_w1;
    t_row    r_s0;
    t_sample r_dl;
    t_sample r_dr;
    t_prod   r_fbl;
    t_prod   r_fbr;
    t_prod   r_prod;
    t_row    r_row;

    t_row    q;
    t_addr   raddr;
    logic    we;
    t_addr   waddr;
    t_row    wdata;

    t_len                   tgt;
    logic [C_LEN_BITS:0]    up;
    logic signed [C_LEN_BITS+1:0] dn;
    t_len                   pos;
    t_addr                  rd_addr;
    t_addr                  nx_addr;
    logic [C_FRAC_BITS-1:0] fr;
    t_addr                  slot_addr;
    t_row                   s1_row;
    t_row                   s0_row;
    t_sample                q_sel;
    t_sample                new_sel;

    // ramp toward clamped target
    always_comb begin
        tgt = (r_delay_target > C_LEN_LIMIT) ? C_LEN_LIMIT : r_delay_target;
        up  = {1'b0, r_cur} + (C_LEN_BITS+1)'(r_smooth_rate);
        dn  = $signed({2'b0, r_cur}) - $signed((C_LEN_BITS+2)'(r_smooth_rate));
        if (tgt > r_cur) begin
            n_cur = (up >= {1'b0, tgt}) ? tgt : up[C_LEN_BITS-1:0];
        end else begin
            n_cur = (dn <= $signed({2'b0, tgt})) ? tgt : dn[C_LEN_BITS-1:0];
        end
    end

    assign pos       = {r_wi, {C_FRAC_BITS{1'b0}}} - r_cur;
    assign rd_addr   = pos[C_LEN_BITS-1:C_FRAC_BITS];
    assign fr        = pos[C_FRAC_BITS-1:0];
    assign nx_addr   = rd_addr + t_addr'(1);
    assign slot_addr = r_wi + r_off;

    always_comb begin
        case (i_cmd.rd_src)
            RD_WI:   raddr = r_wi;
            RD_POS:  raddr = rd_addr;
            RD_NEXT: raddr = nx_addr;
            RD_SLOT: raddr = slot_addr;
            default: raddr = r_wi;
        endcase
    end

    // rows at the write index see the input just added
    assign s0_row = (rd_addr == r_wi) ? r_w1 : q;
    assign s1_row = (nx_addr == r_wi) ? r_w1 : q;

    assign q_sel   = r_ch ? q[C_ROW_BITS-1:C_SAMPLE_BITS] : q[C_SAMPLE_BITS-1:0];

    always_comb begin
        we      = 1'b0;
        waddr   = r_wi;
        wdata   = '0;
        new_sel = '0;
        if (i_cmd.clear_step) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (i_cmd.tick_write) begin
            we    = 1'b1;
            wdata = {sat_add(r_w1[C_ROW_BITS-1:C_SAMPLE_BITS], q_round(r_fbr)),
                     sat_add(r_w1[C_SAMPLE_BITS-1:0], q_round(r_fbl))};
        end else if (i_cmd.scale_write) begin
            we      = 1'b1;
            waddr   = slot_addr;
            new_sel = q_round(r_prod);
            wdata   = r_ch ? {new_sel, r_row[C_SAMPLE_BITS-1:0]}
                           : {r_row[C_ROW_BITS-1:C_SAMPLE_BITS], new_sel};
        end else if (i_cmd.add_write) begin
            we      = 1'b1;
            waddr   = slot_addr;
            new_sel = sat_add(q_sel, r_in_left);
            wdata   = r_ch ? {new_sel, q[C_SAMPLE_BITS-1:0]}
                           : {q[C_ROW_BITS-1:C_SAMPLE_BITS], new_sel};
        end
    end

    sffd_ram #(
        .WIDTH(C_ROW_BITS),
        .DEPTH(C_BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_target <= C_RST_DELAY_TARGET;
            r_smooth_rate  <= C_RST_SMOOTH_RATE;
            r_fb_gain      <= C_RST_FEEDBACK_GAIN;
            r_input_open   <= 1'b1;
            r_output_open  <= 1'b1;
            r_cur          <= C_RST_START_LENGTH;
            r_wi           <= '0;
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DELAY_TARGET:  r_delay_target <= i_cfg_data;
                    CFG_START_LENGTH:  r_cur          <= i_cfg_data;
                    CFG_SMOOTH_RATE:   r_smooth_rate  <= i_cfg_data[C_RATE_BITS-1:0];
                    CFG_FEEDBACK_GAIN: r_fb_gain      <= $signed(i_cfg_data[C_SAMPLE_BITS-1:0]);
                    CFG_INPUT_OPEN:    r_input_open   <= i_cfg_data[0];
                    CFG_OUTPUT_OPEN:   r_output_open  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.ramp) begin
                r_cur <= n_cur;
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
            end
            if (i_cmd.tick_write) begin
                r_wi        <= r_wi + t_addr'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_in_left  <= i_in_left;
            r_in_right <= i_in_right;
            r_coef     <= i_scale_coef;
            r_off      <= t_addr'(i_slot_offset);
            r_ch       <= i_slot_channel;
        end
        if (i_cmd.latch_w1) begin
            r_w1 <= r_input_open
                  ? {sat_add(q[C_ROW_BITS-1:C_SAMPLE_BITS], r_in_right),
                     sat_add(q[C_SAMPLE_BITS-1:0], r_in_left)}
                  : q;
        end
        if (i_cmd.latch_s0) begin
            r_s0 <= s0_row;
        end
        if (i_cmd.latch_dly) begin
            r_dl <= interp(r_s0[C_SAMPLE_BITS-1:0], s1_row[C_SAMPLE_BITS-1:0], fr);
            r_dr <= interp(r_s0[C_ROW_BITS-1:C_SAMPLE_BITS],
                           s1_row[C_ROW_BITS-1:C_SAMPLE_BITS], fr);
        end
        if (i_cmd.latch_fb) begin
            r_fbl <= r_dl * r_fb_gain;
            r_fbr <= r_dr * r_fb_gain;
        end
        if (i_cmd.latch_prod) begin
            r_prod <= q_sel * r_coef;
            r_row  <= q;
        end
        if (i_cmd.tick_write) begin
            o_out_left  <= r_output_open ? r_dl : r_in_left;
            o_out_right <= r_output_open ? r_dr : r_in_right;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.clear_done = (r_clr_addr == {C_ADDR_BITS{1'b1}});
    assign o_stat.out_full   = r_out_valid;
endmodule

`default_nettype wire

/* hw/rtl/sffd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sffd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [1:0]         i_command,
    input  wire sffd_pkg::t_dp_stat i_stat,
    output logic                    o_in_ready,
    output sffd_pkg::t_dp_cmd       o_cmd
);
    import sffd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_TICK:  n_state = S_RAMP;
                        CMD_SCALE: n_state = S_SCALE_RD;
                        CMD_ADD:   n_state = S_ADD_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RAMP:      n_state = S_RD_POS;
            S_RD_POS:    n_state = S_RD_NEXT;
            S_RD_NEXT:   n_state = S_INTERP;
            S_INTERP:    n_state = S_FBMUL;
            S_FBMUL:     n_state = S_WRITE;
            S_WRITE: begin
                if (!i_stat.out_full) begin
                    n_state = S_IDLE;
                end
            end
            S_SCALE_RD:  n_state = S_SCALE_MUL;
            S_SCALE_MUL: n_state = S_SCALE_WR;
            S_SCALE_WR:  n_state = S_IDLE;
            S_ADD_RD:    n_state = S_ADD_WR;
            S_ADD_WR:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.rd_src = RD_WI;
        case (r_state)
            S_CLEAR: o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_RAMP: begin
                o_cmd.ramp   = 1'b1;
                o_cmd.rd_src = RD_WI;
            end
            S_RD_POS: begin
                o_cmd.latch_w1 = 1'b1;
                o_cmd.rd_src   = RD_POS;
            end
            S_RD_NEXT: begin
                o_cmd.latch_s0 = 1'b1;
                o_cmd.rd_src   = RD_NEXT;
            end
            S_INTERP:    o_cmd.latch_dly   = 1'b1;
            S_FBMUL:     o_cmd.latch_fb    = 1'b1;
            S_WRITE:     o_cmd.tick_write  = !i_stat.out_full;
            S_SCALE_RD:  o_cmd.rd_src      = RD_SLOT;
            S_SCALE_MUL: o_cmd.latch_prod  = 1'b1;
            S_SCALE_WR:  o_cmd.scale_write = 1'b1;
            S_ADD_RD:    o_cmd.rd_src      = RD_SLOT;
            S_ADD_WR:    o_cmd.add_write   = 1'b1;
            default: ;
        endcase
    end
endmodule

`default_nettype wire

/* hw/rtl/stereo_feedback_fractional_delay.sv */
// channel   dir  handshake      beat
// i_in      in   valid/ready    command, in_left, in_right, scale_coef, slot_offset, slot_channel
// o_out     out  valid/ready    out_left, out_right
// i_cfg     in   write enable   i_cfg_idx, i_cfg_data
//
// tick: ramp, rd pos, rd next, interp, fbmul, write; store's one read port: 3 row reads, 1 write
// scale: read, multiply, write; add: read, write; unused command: taken and dropped
// reset: clearing pass over all 65536 rows, one row a cycle, ready low; config writes taken
// a tick holds in its write step while the previous result waits in the output register
`timescale 1ns / 1ps
`default_nettype none

module stereo_feedback_fractional_delay (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    sffd_in_if.sink                                   i_in,
    sffd_out_if.source                                o_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [sffd_pkg::C_CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [sffd_pkg::C_CFG_DATA_BITS-1:0] i_cfg_data
);
    import sffd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sffd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .i_stat     (dp_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (dp_cmd)
    );

    sffd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_in_left      (i_in.in_left),
        .i_in_right     (i_in.in_right),
        .i_scale_coef   (i_in.scale_coef),
        .i_slot_offset  (i_in.slot_offset),
        .i_slot_channel (i_in.slot_channel),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_out_left     (o_out.out_left),
        .o_out_right    (o_out.out_right),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );
endmodule

`default_nettype wire

/* hw/rtl/sffd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sffd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [1:0] i_in_command,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready
);
    import sffd_pkg::*;

    // reset empties the output and starts the clearing pass
    `SFFD_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid && !i_in_ready, "reset did not quiet the ports")

    // a real command keeps the block busy in the cycle after it is accepted
    `SFFD_ASSERT(a_busy_after_cmd, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_command == CMD_TICK || i_in_command == CMD_SCALE || i_in_command == CMD_ADD) |=> !i_in_ready, "ready stayed high after a command")

    // a new result comes only out of a busy cycle
    `SFFD_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(!i_in_ready), "result appeared while idle")

    `SFFD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output beat dropped")
endmodule

bind stereo_feedback_fractional_delay sffd_checker u_sffd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready)
);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sffd_pkg::*;

    localparam int         IDLE_PCT       = 11;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         HOLD_CYCLES    = 500;
    localparam int         WATCHDOG_LIMIT = 300000;
    localparam int         N_ROWS         = 38;
    localparam int         N_PHASES       = 5;
    localparam longint     SPAN           = longint'(C_BUFFER_DEPTH) * 256;
    localparam longint     SAMPLE_HI      = 32767;
    localparam longint     SAMPLE_LO      = -32768;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        t_sample     left;
        t_sample     right;
        t_sample     coef;
        logic [15:0] offset;
        logic        chan;
    } t_beat;

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_pair;

    typedef enum logic [1:0] {
        ROW_REG,
        ROW_BEAT,
        ROW_KNOWN
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    reg_idx;
        logic [23:0] reg_val;
        t_beat       beat;
        t_pair       want;
    } t_script_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [C_CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [C_CFG_DATA_BITS-1:0] i_cfg_data;

    sffd_in_if  beat_in();
    sffd_out_if pair_out();

    stereo_feedback_fractional_delay dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (beat_in),
        .o_out      (pair_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // delay line mirror
    t_sample echo_mem [2][C_BUFFER_DEPTH];
    t_addr   wr_ptr;
    t_len    cur_len;
    t_len    tgt_len;
    logic [C_RATE_BITS-1:0] ramp_step;
    t_sample fb_gain;
    logic    in_gate;
    logic    out_gate;

    t_pair pending_pairs [$];

    bit calm;
    bit hold_request;
    int mismatch_count;
    int pairs_checked;
    int reg_writes;
    int n_tick, n_scale, n_add, n_unused;
    int quiet_cycles;

    t_script_row dir_script [N_ROWS] = '{
        '{ROW_KNOWN, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMAX, C_SMIN, 16'sd0, 16'h0000, 1'b0}, '{C_SMAX, C_SMIN}},
        '{ROW_KNOWN, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMIN, C_SMAX, C_SMAX, 16'hFFFF, 1'b1}, '{C_SMIN, C_SMAX}},
        '{ROW_KNOWN, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, 16'sd0, 16'sd0, C_SMIN, 16'h8000, 1'b1}, '{16'sd0, 16'sd0}},
        '{ROW_KNOWN, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, 16'sd1, -16'sd1, 16'sd0, 16'h5555, 1'b0}, '{16'sd1, -16'sd1}},
        '{ROW_REG, CFG_OUTPUT_OPEN, 24'd0, '0, '0},
        '{ROW_KNOWN, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, 16'sd1234, -16'sd4321, 16'sd0, 16'h0000, 1'b0},
          '{16'sd1234, -16'sd4321}},
        '{ROW_KNOWN, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMIN, C_SMAX, 16'sd0, 16'h0000, 1'b0}, '{C_SMIN, C_SMAX}},
        '{ROW_REG, CFG_OUTPUT_OPEN, 24'd1, '0, '0},
        '{ROW_REG, CFG_DELAY_TARGET, 24'h000380, '0, '0},
        '{ROW_REG, CFG_START_LENGTH, 24'h000100, '0, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, 16'sd20000, -16'sd20000, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_SCALE, 16'sd0, 16'sd0, C_SMIN, 16'hFFFF, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_SCALE, 16'sd0, 16'sd0, C_SMAX, 16'h0000, 1'b1}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_ADD, C_SMAX, 16'sd0, 16'sd0, 16'hFFFF, 1'b1}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_ADD, C_SMIN, 16'sd0, 16'sd0, 16'h0001, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_UNUSED, -16'sd1, -16'sd1, -16'sd1, 16'hFFFF, 1'b1}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, -16'sd12345, C_SMAX, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMAX, 16'sd1, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_REG, CFG_SMOOTH_RATE, 24'd0, '0, '0},
        '{ROW_REG, CFG_DELAY_TARGET, 24'hFFFFFF, '0, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, 16'sd300, -16'sd300, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, -16'sd7000, 16'sd7000, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_REG, CFG_START_LENGTH, 24'hFFFFFF, '0, '0},
        '{ROW_REG, CFG_SMOOTH_RATE, 24'h00FFFF, '0, '0},
        '{ROW_REG, CFG_DELAY_TARGET, 24'd0, '0, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, 16'sd5, 16'sd6, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMIN, C_SMIN, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_REG, CFG_FEEDBACK_GAIN, 24'h008000, '0, '0},
        '{ROW_REG, CFG_INPUT_OPEN, 24'd0, '0, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMAX, C_SMIN, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_REG, CFG_INPUT_OPEN, 24'd1, '0, '0},
        '{ROW_REG, CFG_FEEDBACK_GAIN, 24'h007FFF, '0, '0},
        '{ROW_REG, CFG_DELAY_TARGET, 24'h000080, '0, '0},
        '{ROW_REG, CFG_START_LENGTH, 24'd0, '0, '0},
        '{ROW_REG, CFG_SMOOTH_RATE, 24'h000040, '0, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMIN, C_SMIN, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, C_SMAX, C_SMAX, 16'sd0, 16'h0000, 1'b0}, '0},
        '{ROW_BEAT, CFG_DELAY_TARGET, 24'd0,
          '{CMD_TICK, 16'sd100, -16'sd100, 16'sd0, 16'h0000, 1'b0}, '0}
    };

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40) begin
            $display("tb_top: mismatch at %0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    function automatic t_sample clip(input longint v);
        if (v > SAMPLE_HI) begin
            return t_sample'(SAMPLE_HI);
        end
        if (v < SAMPLE_LO) begin
            return t_sample'(SAMPLE_LO);
        end
        return t_sample'(v);
    endfunction

    function automatic t_sample q15_mul(input longint a, input longint b);
        return clip((a * b + 16384) >>> 15);
    endfunction

    function automatic void accumulate(input int ch, input t_addr idx, input longint v);
        echo_mem[ch][idx] = clip(longint'(echo_mem[ch][idx]) + v);
    endfunction

    function automatic longint blend(input int ch, input t_addr rd, input longint fr);
        t_addr nx;
        nx = rd + 1'b1;
        return (longint'(echo_mem[ch][rd]) * (256 - fr)
              + longint'(echo_mem[ch][nx]) * fr + 128) >>> 8;
    endfunction

    // advances the mirror by one beat; returns 1 when the beat yields an output pair
    function automatic bit run_delay_line(input t_beat b, output t_pair pair);
        t_addr  slot;
        longint tgt, val, pos, fr, dl, dr;
        t_addr  rd;
        pair = '0;
        slot = wr_ptr + b.offset;
        if (b.command == CMD_SCALE) begin
            echo_mem[b.chan][slot] = q15_mul(echo_mem[b.chan][slot], b.coef);
            return 1'b0;
        end
        if (b.command == CMD_ADD) begin
            accumulate(b.chan, slot, b.left);
            return 1'b0;
        end
        if (b.command != CMD_TICK) begin
            return 1'b0;
        end
        tgt = (tgt_len > C_LEN_LIMIT) ? longint'(C_LEN_LIMIT) : longint'(tgt_len);
        val = longint'(cur_len);
        if (tgt > val) begin
            val = val + longint'(ramp_step);
            if (val >= tgt) val = tgt;
        end else begin
            val = val - longint'(ramp_step);
            if (val <= tgt) val = tgt;
        end
        cur_len = t_len'(val);
        pos = (longint'(wr_ptr) * 256 + SPAN - (longint'(cur_len) % SPAN)) % SPAN;
        rd  = t_addr'(pos >> 8);
        fr  = pos & 255;
        if (in_gate) begin
            accumulate(0, wr_ptr, b.left);
            accumulate(1, wr_ptr, b.right);
        end
        dl = blend(0, rd, fr);
        dr = blend(1, rd, fr);
        accumulate(0, wr_ptr, q15_mul(dl, fb_gain));
        accumulate(1, wr_ptr, q15_mul(dr, fb_gain));
        wr_ptr = wr_ptr + 1'b1;
        if (out_gate) begin
            pair.left  = t_sample'(dl);
            pair.right = t_sample'(dr);
        end else begin
            pair.left  = b.left;
            pair.right = b.right;
        end
        return 1'b1;
    endfunction

    function automatic t_sample rand_sample();
        case ($urandom_range(9))
            0: return C_SMAX;
            1: return C_SMIN;
            2: return t_sample'(int'($urandom_range(200)) - 100);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 70) b.command = CMD_TICK;
        else if (pick < 82) b.command = CMD_SCALE;
        else if (pick < 94) b.command = CMD_ADD;
        else b.command = CMD_UNUSED;
        b.left  = rand_sample();
        b.right = rand_sample();
        b.coef  = rand_sample();
        case ($urandom_range(2))
            0: b.offset = 16'($urandom_range(40));
            1: b.offset = 16'(-int'($urandom_range(1, 40)));
            default: b.offset = 16'($urandom);
        endcase
        b.chan = 1'($urandom);
        return b;
    endfunction

    task automatic send_beat(input t_beat b, input bit known, input t_pair want);
        t_pair got;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            beat_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        beat_in.valid        <= 1'b1;
        beat_in.command      <= b.command;
        beat_in.in_left      <= b.left;
        beat_in.in_right     <= b.right;
        beat_in.scale_coef   <= b.coef;
        beat_in.slot_offset  <= b.offset;
        beat_in.slot_channel <= b.chan;
        do @(posedge i_clk); while (beat_in.ready !== 1'b1);
        if (run_delay_line(b, got)) begin
            pending_pairs.push_back(known ? want : got);
        end
        case (b.command)
            CMD_TICK:  n_tick++;
            CMD_SCALE: n_scale++;
            CMD_ADD:   n_add++;
            default:   n_unused++;
        endcase
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_DELAY_TARGET:  tgt_len = val;
            CFG_START_LENGTH:  cur_len = val;
            CFG_SMOOTH_RATE:   ramp_step = val[15:0];
            CFG_FEEDBACK_GAIN: fb_gain = val[15:0];
            CFG_INPUT_OPEN:    in_gate = val[0];
            CFG_OUTPUT_OPEN:   out_gate = val[0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, drain all pending pairs, let a trailing scale or add finish
    task automatic quiesce();
        beat_in.valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side: ready pattern and pair checks
    initial begin
        int    hold_left;
        t_pair want;
        hold_left = 0;
        pair_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pair_out.valid === 1'b1 && pair_out.ready === 1'b1) begin
                pairs_checked++;
                if (pending_pairs.size() == 0) begin
                    report_mismatch("output pair with nothing pending");
                end else begin
                    want = pending_pairs.pop_front();
                    if (pair_out.out_left !== want.left) begin
                        report_mismatch($sformatf("pair %0d out_left got %0d want %0d",
                            pairs_checked, pair_out.out_left, want.left));
                    end
                    if (pair_out.out_right !== want.right) begin
                        report_mismatch($sformatf("pair %0d out_right got %0d want %0d",
                            pairs_checked, pair_out.out_right, want.right));
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pair_out.ready <= 1'b0;
            end else if (calm) begin
                pair_out.ready <= 1'b1;
            end else begin
                pair_out.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((beat_in.valid === 1'b1 && beat_in.ready === 1'b1) ||
                (pair_out.valid === 1'b1 && pair_out.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: no beat moved for %0d cycles", quiet_cycles);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int phase_len [N_PHASES];
        phase_len            = '{150, 150, 120, 100, 160};
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_DELAY_TARGET;
        i_cfg_data           <= '0;
        beat_in.valid        <= 1'b0;
        beat_in.command      <= CMD_TICK;
        beat_in.in_left      <= '0;
        beat_in.in_right     <= '0;
        beat_in.scale_coef   <= '0;
        beat_in.slot_offset  <= '0;
        beat_in.slot_channel <= 1'b0;
        calm         = 1'b0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        for (int i = 0; i < C_BUFFER_DEPTH; i++) begin
            echo_mem[0][i] = '0;
            echo_mem[1][i] = '0;
        end
        wr_ptr    = '0;
        cur_len   = C_RST_START_LENGTH;
        tgt_len   = C_RST_DELAY_TARGET;
        ramp_step = C_RST_SMOOTH_RATE;
        fb_gain   = C_RST_FEEDBACK_GAIN;
        in_gate   = 1'b1;
        out_gate  = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_script[i]) begin
            if (dir_script[i].kind == ROW_REG) begin
                if (i == 0 || dir_script[i-1].kind != ROW_REG) quiesce();
                write_reg(dir_script[i].reg_idx, dir_script[i].reg_val);
            end else begin
                send_beat(dir_script[i].beat, dir_script[i].kind == ROW_KNOWN,
                          dir_script[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            quiesce();
            calm = (ph == 2);
            case (ph)
                0: begin
                    write_reg(CFG_DELAY_TARGET, 24'($urandom_range(256, 30 * 256)));
                    write_reg(CFG_START_LENGTH, 24'($urandom_range(30 * 256)));
                    write_reg(CFG_SMOOTH_RATE, 24'($urandom_range(1, 1023)));
                    write_reg(CFG_FEEDBACK_GAIN, 24'($urandom));
                    write_reg(CFG_INPUT_OPEN, 24'd1);
                    write_reg(CFG_OUTPUT_OPEN, 24'd1);
                end
                1: begin
                    write_reg(CFG_DELAY_TARGET, 24'($urandom_range(8 * 256)));
                    write_reg(CFG_START_LENGTH, 24'($urandom_range(255)));
                    write_reg(CFG_SMOOTH_RATE, 24'($urandom_range(16, 300)));
                    write_reg(CFG_FEEDBACK_GAIN, 24'h007FFF);
                    write_reg(CFG_INPUT_OPEN, 24'($urandom) | 24'd1);
                    write_reg(CFG_OUTPUT_OPEN, 24'd1);
                end
                2: begin
                    write_reg(CFG_DELAY_TARGET, 24'($urandom_range(512, 64 * 256)));
                    write_reg(CFG_START_LENGTH, 24'($urandom_range(64 * 256)));
                    write_reg(CFG_SMOOTH_RATE, 24'($urandom));
                    write_reg(CFG_FEEDBACK_GAIN, 24'($urandom));
                    write_reg(CFG_INPUT_OPEN, 24'($urandom));
                    write_reg(CFG_OUTPUT_OPEN, 24'($urandom));
                end
                3: begin
                    write_reg(CFG_DELAY_TARGET, 24'($urandom));
                    write_reg(CFG_START_LENGTH, 24'($urandom));
                    write_reg(CFG_SMOOTH_RATE, 24'h00FFFF);
                    write_reg(CFG_FEEDBACK_GAIN, 24'($urandom));
                    write_reg(CFG_INPUT_OPEN, 24'd1);
                    write_reg(CFG_OUTPUT_OPEN, 24'd1);
                end
                default: begin
                    write_reg(CFG_DELAY_TARGET, 24'($urandom_range(16 * 256)));
                    write_reg(CFG_START_LENGTH, 24'($urandom_range(128, 16 * 256)));
                    write_reg(CFG_SMOOTH_RATE, 24'd0);
                    write_reg(CFG_FEEDBACK_GAIN, 24'h008000);
                    write_reg(CFG_INPUT_OPEN, 24'd1);
                    write_reg(CFG_OUTPUT_OPEN, 24'd1);
                end
            endcase
            for (int k = 0; k < phase_len[ph]; k++) begin
                // output stalls for a long stretch while ticks keep coming
                if (ph == 1 && k == 20) hold_request = 1'b1;
                send_beat(rand_beat(), 1'b0, '0);
            end
        end
        calm = 1'b0;
        quiesce();

        $display("tb_top: %0d beats in (%0d ticks, %0d scales, %0d adds, %0d unused), %0d reg writes",
                 n_tick + n_scale + n_add + n_unused, n_tick, n_scale, n_add, n_unused,
                 reg_writes);
        $display("tb_top: %0d output pairs checked, %0d mismatches",
                 pairs_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sffd_pkg.sv
hw/rtl/sffd_in_if.sv
hw/rtl/sffd_out_if.sv
hw/rtl/sffd_ram.sv
hw/rtl/sffd_dp.sv
hw/rtl/sffd_ctrl.sv
hw/rtl/stereo_feedback_fractional_delay.sv
hw/rtl/sffd_checker.sv
verif/tb_top.sv
